// File: hdl/timestamp_interpolating_association_top_defines.svh
// Assertion macros used by the checker file.
`ifndef TIMESTAMP_INTERPOLATING_ASSOCIATION_TOP_DEFINES_SVH
`define TIMESTAMP_INTERPOLATING_ASSOCIATION_TOP_DEFINES_SVH

// Checks that an implication holds on every clock edge outside reset.
`define TIA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define TIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/tia_pkg.sv
`timescale 1ns / 1ps
package tia_pkg;

   localparam int unsigned REF_DEPTH_DEFAULT  = 1024;
   localparam int unsigned RATIO_BITS_DEFAULT = 16;
   localparam int unsigned TIME_W             = 63;
   localparam int unsigned POS_W              = 32;
   localparam int unsigned GAP_W              = 40;
   localparam int unsigned IDX_W              = 16;
   localparam logic [GAP_W-1:0] MAX_GAP_RESET = 40'd110000000;

   // Operation codes.
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_EST     = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_ASSOC  = 2'd0;
   localparam logic [1:0] ST_BEFORE = 2'd1;
   localparam logic [1:0] ST_NOLATE = 2'd2;
   localparam logic [1:0] ST_GAP    = 2'd3;

   typedef struct packed {
      logic [1:0]        op;
      logic [TIME_W-1:0] sample_time;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [TIME_W-1:0] match_time;
      logic signed [POS_W-1:0] est_x;
      logic signed [POS_W-1:0] est_y;
      logic signed [POS_W-1:0] est_z;
      logic signed [POS_W-1:0] interp_x;
      logic signed [POS_W-1:0] interp_y;
      logic signed [POS_W-1:0] interp_z;
      logic [IDX_W-1:0]  assoc_index;
   } rsp_type;

   // Control between sequencer and divider.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

// File: hdl/tia_div.sv
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle; the internal quotient is RATIO_BITS+1
// wide so that a dividend at or above the divisor is represented, but only its low RATIO_BITS bits reach the port.
module tia_div
   import tia_pkg::*;
#(
   parameter int unsigned RATIO_BITS = RATIO_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [TIME_W-1:0]        dividend,
   input  logic [TIME_W-1:0]        divisor,
   output div_ctl_type              ctl,
   output logic [RATIO_BITS-1:0]    quotient
);
   localparam int unsigned CNT_W = $clog2(RATIO_BITS + 2);

   logic [TIME_W:0]        rem_ff, rem_in;
   logic [TIME_W-1:0]      den_ff, den_in;
   logic [RATIO_BITS:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in, done_ff, done_in;
   logic [TIME_W:0]        trial;
   logic [TIME_W+1:0]      shifted;

   // One shift and subtract step per cycle.
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, 1'b0};
      trial   = shifted[TIME_W:0] - {1'b0, den_ff};
      if (start) begin
         // First step compares the raw dividend (bit RATIO_BITS of the quotient).
         rem_in  = {1'b0, dividend};
         den_in  = divisor;
         quo_in  = '0;
         cnt_in  = CNT_W'(RATIO_BITS + 1);
         busy_in = 1'b1;
         if ({1'b0, dividend} >= {1'b0, divisor}) begin
            rem_in = {1'b0, dividend} - {1'b0, divisor};
            quo_in = {1'b1, {RATIO_BITS{1'b0}}};
         end
         cnt_in = CNT_W'(RATIO_BITS);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            if (!shifted[TIME_W+1] && shifted[TIME_W:0] >= {1'b0, den_ff}) begin
               rem_in = trial;
               quo_in = {quo_ff[RATIO_BITS-1:0], 1'b1};
            end else begin
               rem_in = shifted[TIME_W:0];
               quo_in = {quo_ff[RATIO_BITS-1:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign quotient  = quo_ff[RATIO_BITS-1:0];
endmodule

// File: hdl/timestamp_interpolating_association_top.sv
`timescale 1ns / 1ps
// Associates estimate samples with a loaded reference table by linear
// interpolation. A load or restart beat passes through S_FIN. An estimate beat
// walks a forward-only cursor through the reference memory, one S_RDN and
// S_WALK pass per reference stepped over, then runs a bit-serial divider and
// three shared multiply steps. req_stall is high for the whole of that work
// and while a finished result waits for the previous one to leave the
// output register. One result beat is given per estimate, none for other
// operations.
module timestamp_interpolating_association_top
   import tia_pkg::*;
#(
   parameter int unsigned REF_DEPTH  = REF_DEPTH_DEFAULT,
   parameter int unsigned RATIO_BITS = RATIO_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [GAP_W-1:0]  csr_data
);
   localparam int unsigned AW = $clog2(REF_DEPTH);
   localparam int unsigned CW = AW + 1;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_RD0   = 11'b00000000010,
      S_CHK   = 11'b00000000100,
      S_RDN   = 11'b00000001000,
      S_WALK  = 11'b00000010000,
      S_DIV   = 11'b00000100000,
      S_MUL   = 11'b00001000000,
      S_ADD   = 11'b00010000000,
      S_OUT   = 11'b00100000000,
      S_FIN   = 11'b01000000000,
      S_RDC   = 11'b10000000000
   } state_type;

   // Reference memories.
   logic [TIME_W-1:0] time_mem [REF_DEPTH];
   logic [POS_W-1:0]  x_mem [REF_DEPTH];
   logic [POS_W-1:0]  y_mem [REF_DEPTH];
   logic [POS_W-1:0]  z_mem [REF_DEPTH];

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in, cursor_ff, cursor_in;
   logic [IDX_W-1:0]  assoc_ff, assoc_in;
   logic              started_ff, started_in;
   logic [GAP_W-1:0]  gap_max_ff;
   req_type           item_ff, item_in;
   rsp_type           wrk_ff, wrk_in;         // result being assembled
   rsp_type           out_ff, out_in;
   logic              out_vld_ff, out_vld_in;
   logic [TIME_W-1:0] t0_ff, t0_in;           // time of the first reference
   logic [TIME_W-1:0] tc_ff, tc_in;           // time at the cursor
   logic [POS_W-1:0]  ax_ff, ay_ff, az_ff;    // position at the cursor
   logic [AW-1:0]     rd_addr;
   logic              rd_en;
   logic [TIME_W-1:0] rd_time;
   logic [POS_W-1:0]  rd_x, rd_y, rd_z;
   logic [1:0]        lane_ff, lane_in;
   logic [POS_W-1:0]  bx_ff, by_ff, bz_ff;
   logic              div_start;
   div_ctl_type       div_ctl;
   logic [RATIO_BITS-1:0] ratio;
   logic signed [POS_W+RATIO_BITS+1:0] prod_ff, prod_in;
   logic signed [POS_W:0]   diff;
   logic signed [POS_W-1:0] sel_a, sel_b;
   logic [POS_W-1:0]  res_ff [3];
   logic [POS_W-1:0]  res_val;
   logic [TIME_W-1:0] gap;
   logic [CW-1:0]     nxt;

   assign nxt = cursor_ff + 1'b1;
   assign gap = rd_time - tc_ff;

   // Memory write on load, registered read at rd_addr.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid && item_in.op == OP_LOAD
          && count_ff < CW'(REF_DEPTH)) begin
         time_mem[count_ff[AW-1:0]] <= req_data.sample_time;
         x_mem[count_ff[AW-1:0]]    <= req_data.pos_x;
         y_mem[count_ff[AW-1:0]]    <= req_data.pos_y;
         z_mem[count_ff[AW-1:0]]    <= req_data.pos_z;
      end
      if (rd_en) begin
         rd_time <= time_mem[rd_addr];
         rd_x    <= x_mem[rd_addr];
         rd_y    <= y_mem[rd_addr];
         rd_z    <= z_mem[rd_addr];
      end
   end

   // The divider produces the fraction dt / gap, which is below one.
   tia_div #(.RATIO_BITS(RATIO_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(item_ff.sample_time - tc_ff),
      .divisor(gap), .ctl(div_ctl), .quotient(ratio)
   );

   // Shared multiplier lane select. The product is registered in S_MUL and
   // added to the cursor position in S_ADD.
   always_comb begin
      unique case (lane_ff)
         2'd0:    begin sel_a = ax_ff; sel_b = bx_ff; end
         2'd1:    begin sel_a = ay_ff; sel_b = by_ff; end
         default: begin sel_a = az_ff; sel_b = bz_ff; end
      endcase
      diff    = {sel_b[POS_W-1], sel_b} - {sel_a[POS_W-1], sel_a};
      prod_in = (POS_W+RATIO_BITS+2)'(diff) * $signed({1'b0, ratio});
      res_val = POS_W'(sel_a + POS_W'(prod_ff >>> RATIO_BITS));
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      assoc_in   = assoc_ff;
      started_in = started_ff;
      item_in    = item_ff;
      wrk_in     = wrk_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && rsp_stall;
      t0_in      = t0_ff;
      tc_in      = tc_ff;
      lane_in    = lane_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      div_start  = 1'b0;
      if (state_ff == S_IDLE) item_in = req_data;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.op == OP_LOAD) begin
                  if (count_ff < CW'(REF_DEPTH)) count_in = count_ff + 1'b1;
                  state_in = S_FIN;
               end else if (req_data.op == OP_RESTART) begin
                  count_in = '0; cursor_in = '0; assoc_in = '0; started_in = 1'b0;
                  state_in = S_FIN;
               end else if (req_data.op == OP_EST) begin
                  started_in = 1'b1;
                  rd_en = 1'b1; rd_addr = '0;
                  state_in = S_RD0;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_RD0: begin
            t0_in = rd_time;
            rd_en = 1'b1; rd_addr = cursor_ff[AW-1:0];
            state_in = S_RDC;
         end
         S_RDC: begin
            tc_in = rd_time;
            state_in = S_CHK;
         end
         S_CHK: begin
            wrk_in.match_time = item_ff.sample_time;
            wrk_in.est_x = item_ff.pos_x;
            wrk_in.est_y = item_ff.pos_y;
            wrk_in.est_z = item_ff.pos_z;
            wrk_in.interp_x = '0; wrk_in.interp_y = '0; wrk_in.interp_z = '0;
            wrk_in.assoc_index = assoc_ff;
            if (count_ff == '0 || item_ff.sample_time < t0_ff
                || item_ff.sample_time < tc_ff) begin
               wrk_in.status = ST_BEFORE;
               state_in = S_OUT;
            end else begin
               state_in = S_RDN;
            end
         end
         S_RDN: begin
            // Read the successor of the cursor.
            if (nxt < count_ff) begin
               rd_en = 1'b1; rd_addr = nxt[AW-1:0];
               state_in = S_WALK;
            end else begin
               wrk_in.status = ST_NOLATE;
               state_in = S_OUT;
            end
         end
         S_WALK: begin
            if (rd_time <= item_ff.sample_time) begin
               cursor_in = nxt;
               tc_in = rd_time;
               state_in = S_RDN;
            end else if (gap > TIME_W'(gap_max_ff)) begin
               wrk_in.status = ST_GAP;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_ctl.done) begin
               lane_in = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            if (lane_ff == 2'd2) begin
               wrk_in.interp_x = res_ff[0];
               wrk_in.interp_y = res_ff[1];
               wrk_in.interp_z = res_val;
               wrk_in.status = ST_ASSOC;
               if (assoc_ff != '1) assoc_in = assoc_ff + 1'b1;
               state_in = S_OUT;
            end else begin
               lane_in = lane_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_OUT: begin
            if (!out_vld_ff || !rsp_stall) begin
               out_in = wrk_ff;
               out_vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FIN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      wrk_ff  <= wrk_in;
      out_ff  <= out_in;
      t0_ff   <= t0_in;
      tc_ff   <= tc_in;
      lane_ff <= lane_in;
      prod_ff <= prod_in;
      // Keep the cursor and successor positions for the lerp.
      if (state_ff == S_RDC) begin
         ax_ff <= rd_x; ay_ff <= rd_y; az_ff <= rd_z;
      end
      if (state_ff == S_WALK) begin
         if (rd_time <= item_ff.sample_time) begin
            ax_ff <= rd_x; ay_ff <= rd_y; az_ff <= rd_z;
         end else begin
            bx_ff <= rd_x; by_ff <= rd_y; bz_ff <= rd_z;
         end
      end
      if (state_ff == S_ADD) res_ff[lane_ff] <= res_val;
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         cursor_ff  <= '0;
         assoc_ff   <= '0;
         started_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         gap_max_ff <= MAX_GAP_RESET;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cursor_ff  <= cursor_in;
         assoc_ff   <= assoc_in;
         started_ff <= started_in;
         out_vld_ff <= out_vld_in;
         if (csr_valid) gap_max_ff <= csr_data;
      end
   end

   assign req_stall = (state_ff != S_IDLE) || (started_ff && 1'b0);
   assign csr_ready = 1'b1;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;
endmodule

// File: hdl/tia_checker.sv
`timescale 1ns / 1ps
`include "timestamp_interpolating_association_top_defines.svh"
// Port-level checks for the association block.
module tia_checker
   import tia_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   // A stalled result beat holds.
   `TIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // Each accepted request raises req_stall in the cycle after it.
   `TIA_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && !req_stall, req_stall)
   // A skipped estimate carries no interpolated position.
   `TIA_ASSERT_IMPL(a_skip_zero, clock, reset, rsp_valid && rsp_data.status != ST_ASSOC,
      rsp_data.interp_x == '0 && rsp_data.interp_y == '0 && rsp_data.interp_z == '0)
endmodule

bind timestamp_interpolating_association_top tia_checker u_tia_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

// File: test/tb_timestamp_interpolating_association_top.sv
`timescale 1ns / 1ps
module tb_timestamp_interpolating_association_top;
   import tia_pkg::*;

   localparam int unsigned DEPTH     = 1024;
   localparam int unsigned RBITS     = 16;
   localparam int unsigned WDOG_MAX  = 200000;

   // Association predictor with its own copy of the reference table.
   class assoc_scoreboard;
      logic [TIME_W-1:0]      tstore [DEPTH];
      logic signed [31:0]     xstore [DEPTH];
      logic signed [31:0]     ystore [DEPTH];
      logic signed [31:0]     zstore [DEPTH];
      int unsigned            nrefs;
      int unsigned            cur;
      int unsigned            nassoc;
      logic [GAP_W-1:0]       gap_limit;
      rsp_type                pending [$];
      int unsigned            errors;
      int unsigned            nchecked;
      int unsigned            status_seen [4];

      function new();
         nrefs = 0;
         cur = 0;
         nassoc = 0;
         gap_limit = MAX_GAP_RESET;
         errors = 0;
         nchecked = 0;
      endfunction

      function logic signed [31:0] lerp(logic signed [31:0] a, logic signed [31:0] b,
                                        longint unsigned ratio);
         longint d;
         longint p;
         d = longint'(b) - longint'(a);
         p = d * longint'(ratio);
         return 32'(longint'(a) + (p >>> RBITS));
      endfunction

      // Notes one accepted beat and queues the result it causes.
      function void note_request(req_type r);
         rsp_type e;
         logic [63:0] gap;
         logic [63:0] dt;
         logic [127:0] ratio;
         logic [TIME_W-1:0] t;
         t = r.sample_time;
         if (r.op == OP_LOAD) begin
            if (nrefs < DEPTH) begin
               tstore[nrefs] = t;
               xstore[nrefs] = r.pos_x;
               ystore[nrefs] = r.pos_y;
               zstore[nrefs] = r.pos_z;
               nrefs++;
            end
            return;
         end
         if (r.op == OP_RESTART) begin
            nrefs = 0;
            cur = 0;
            nassoc = 0;
            return;
         end
         if (r.op != OP_EST) return;
         e = '0;
         e.match_time = t;
         e.est_x = r.pos_x;
         e.est_y = r.pos_y;
         e.est_z = r.pos_z;
         if (nrefs == 0 || t < tstore[0] || t < tstore[cur]) begin
            e.status = ST_BEFORE;
         end else begin
            while (cur + 1 < nrefs && tstore[cur+1] <= t) cur++;
            if (cur + 1 >= nrefs) begin
               e.status = ST_NOLATE;
            end else begin
               gap = 64'(tstore[cur+1]) - 64'(tstore[cur]);
               if (gap > 64'(gap_limit) || gap == 0) begin
                  e.status = ST_GAP;
               end else begin
                  dt = 64'(t) - 64'(tstore[cur]);
                  ratio = (128'(dt) << RBITS) / 128'(gap);
                  e.interp_x = lerp(xstore[cur], xstore[cur+1], 64'(ratio));
                  e.interp_y = lerp(ystore[cur], ystore[cur+1], 64'(ratio));
                  e.interp_z = lerp(zstore[cur], zstore[cur+1], 64'(ratio));
                  e.status = ST_ASSOC;
               end
            end
         end
         e.assoc_index = 16'(nassoc);
         if (e.status == ST_ASSOC && nassoc < 65535) nassoc++;
         pending.push_back(e);
      endfunction

      // Compares one result beat against the oldest expectation.
      function void check_result(rsp_type got);
         rsp_type e;
         nchecked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected result %p", got);
            return;
         end
         e = pending.pop_front();
         status_seen[e.status]++;
         if (got !== e) begin
            errors++;
            if (errors <= 10) $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                                       e, got);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [GAP_W-1:0]  csr_data;

   assoc_scoreboard   board;
   bit                quiet_mode;
   bit                hold_rsp;
   int unsigned       idle_cycles;
   int unsigned       n_sent;

   timestamp_interpolating_association_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Receiver: random stalls, or a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         rsp_stall <= hold_rsp || (!quiet_mode && $urandom_range(99) < 7);
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Sends one beat, with a possible random gap first.
   task automatic send_beat(req_type r);
      if (!quiet_mode && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      n_sent++;
   endtask

   task automatic send_op(logic [1:0] op, logic [TIME_W-1:0] t, logic signed [31:0] x,
                          logic signed [31:0] y, logic signed [31:0] z);
      req_type r;
      r.op = op;
      r.sample_time = t;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      send_beat(r);
   endtask

   function automatic logic signed [31:0] rand_pos();
      case ($urandom_range(3))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   // Waits for every result, then for the block to settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_gap(logic [GAP_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.gap_limit = v;
   endtask

   // A random track: a restart, mostly sorted references, then mostly sorted estimates with extras.
   task automatic run_track(int unsigned nref, int unsigned nest, int unsigned step_max);
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] base;
      logic [TIME_W-1:0] span;
      base = TIME_W'({$urandom, $urandom}) & 63'h0FFF_FFFF_FFFF_FFFF;
      t = base;
      send_op(OP_RESTART, TIME_W'({$urandom, $urandom}), $urandom, $urandom, $urandom);
      for (int i = 0; i < nref; i++) begin
         // Occasionally a duplicate or out-of-order reference time.
         if ($urandom_range(19) == 0) t = t - TIME_W'($urandom_range(0, 50));
         else t = t + TIME_W'($urandom_range(1, step_max));
         send_op(OP_LOAD, t, rand_pos(), rand_pos(), rand_pos());
      end
      span = t - base;
      t = base - TIME_W'($urandom_range(0, 20));
      for (int i = 0; i < nest; i++) begin
         if ($urandom_range(9) == 0) t = t - TIME_W'($urandom_range(0, step_max));
         else t = t + TIME_W'($urandom_range(0,
                                  32'(2 * (span / TIME_W'(nest + 1)) + 1)));
         if ($urandom_range(29) == 0) send_op(OP_UNUSED, t, $urandom, $urandom, $urandom);
         send_op(OP_EST, t, rand_pos(), rand_pos(), rand_pos());
      end
   endtask

   initial begin
      board = new();
      quiet_mode = 1'b0;
      hold_rsp = 1'b0;
      n_sent = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      rsp_stall = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extremes, every status and code.
      send_op(OP_EST, 63'd0, 32'sh7FFFFFFF, 32'sh80000000, 0);
      send_op(OP_LOAD, 63'd1000, 32'sh80000000, 32'sh7FFFFFFF, 0);
      send_op(OP_EST, 63'd999, 1, 2, 3);
      send_op(OP_LOAD, 63'd1000, 5, 5, 5);
      send_op(OP_LOAD, 63'd2000, 32'sh7FFFFFFF, 32'sh80000000, -100);
      send_op(OP_EST, 63'd1000, 0, 0, 0);
      send_op(OP_EST, 63'd1500, 0, 0, 0);
      send_op(OP_EST, 63'd1999, 0, 0, 0);
      send_op(OP_EST, 63'd1200, 0, 0, 0);
      send_op(OP_LOAD, 63'd200000000, 7, 7, 7);
      send_op(OP_LOAD, 63'h7FFFFFFFFFFFFFFF, -1, -1, -1);
      send_op(OP_EST, 63'd100000000, 0, 0, 0);
      send_op(OP_UNUSED, 63'h7FFFFFFFFFFFFFFF, -1, -1, -1);
      send_op(OP_EST, 63'h7FFFFFFFFFFFFFFF, -1, -1, -1);
      drain();
      write_gap(40'hFFFFFFFFFF);
      send_op(OP_RESTART, 0, 0, 0, 0);
      send_op(OP_LOAD, 63'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      send_op(OP_LOAD, 63'h7FFFFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_op(OP_LOAD, 63'h7FFFFFFFFFFFFFFF, 0, 0, 0);
      send_op(OP_EST, 63'h3FFFFFFFFF, 0, 0, 0);
      send_op(OP_EST, 63'h7FFFFFFFFE, 0, 0, 0);
      send_op(OP_EST, 63'h8000000000, 0, 0, 0);
      drain();
      write_gap(40'd0);
      send_op(OP_EST, 63'd1, 0, 0, 0);
      drain();

      // Random phases over several gap limits.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_gap(MAX_GAP_RESET);
            1: write_gap(40'd1000);
            2: write_gap(40'hFFFFFFFFFF);
            3: write_gap(GAP_W'({$urandom_range(255), $urandom}));
            default: write_gap(40'd600);
         endcase
         quiet_mode = (ph == 2);
         for (int k = 0; k < 3; k++) run_track($urandom_range(3, 12), $urandom_range(5, 15),
                                                (ph == 3) ? 32'hFFFFFFF : 1000);
         drain();
      end

      // Fill the table past its depth, then hold the receiver off.
      write_gap(40'hFFFFFFFFFF);
      quiet_mode = 1'b1;
      run_track(DEPTH + 3, 4, 1000);
      drain();
      quiet_mode = 1'b0;
      hold_rsp = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         run_track(6, 12, 1000);
      join
      drain();

      $display("Run covered %0d input beats and %0d result beats.", n_sent, board.nchecked);
      $display("Statuses seen: assoc %0d, before %0d, no later %0d, gap %0d.",
               board.status_seen[0], board.status_seen[1], board.status_seen[2],
               board.status_seen[3]);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// File: timestamp_interpolating_association_top.f
+incdir+hdl
hdl/tia_pkg.sv
hdl/tia_div.sv
hdl/timestamp_interpolating_association_top.sv
hdl/tia_checker.sv
test/tb_timestamp_interpolating_association_top.sv
